### src/humidity_temperature_frame_decoder_assert.svh
// assertion macros used by the frame decoder checker
`ifndef HUMIDITY_TEMPERATURE_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define HTFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/htfd_pkg.sv
// shared types, constants and crc function of the frame decoder
`timescale 1ns / 1ps

package htfd_pkg;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    localparam int TEMP_W   = 15;
    localparam int HUM_W    = 14;
    localparam int STATUS_W = 2;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [2:0] FRAME_BYTES = 3'd6;

    // byte positions inside one readout
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TEMP_CRC = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_HUM_CRC  = 2'd2;

    // scaling: floor(span * raw / 65535) - offset
    localparam logic [14:0]       TEMP_SPAN   = 15'd17500;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0]       HUM_SPAN    = 14'd12500;
    localparam logic [HUM_W-1:0]  HUM_OFFSET  = 14'd600;
    localparam logic [HUM_W-1:0]  HUM_MAX     = 14'd10000;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [15:0]         temp_word;
        logic [15:0]         hum_word;
    } t_frame_rec;

    // one byte through the crc-8, msb first, no final xor
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### src/humidity_temperature_frame_decoder.sv
// top level: six-byte readout decoder with crc check and fixed point scaling
// throughput: one byte transfer per cycle, sustained while the result side drains
// after its sixth byte transfer, a frame's result is registered in turn in the
//   frame record register, the product register and the result register
// a held result stalls the input once record, product and result registers are all full
// reset: synchronous active low; clears byte position, crc, words and all valid flags
`timescale 1ns / 1ps

module humidity_temperature_frame_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [htfd_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
    input  logic [htfd_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // [0] frame_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [htfd_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [14:0] temperature_centi,
                                                           // [28:15] humidity_centi, zero fill
    output logic [htfd_pkg::M_TUSER_W-1:0]  m_axis_tuser   // [1:0] frame_status
);
    import htfd_pkg::*;

    t_frame_rec          w_rec;
    logic                w_rec_ready;
    logic                w_in_ready;
    logic [TEMP_W-1:0]   w_temp;
    logic [HUM_W-1:0]    w_hum;
    logic [STATUS_W-1:0] w_status;

    htfd_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_axis_tvalid && w_in_ready),
        .i_rx_byte     (s_axis_tdata[7:0]),
        .i_frame_start (s_axis_tuser[0]),
        .i_rec_ready   (w_rec_ready),
        .o_in_ready    (w_in_ready),
        .o_rec         (w_rec)
    );

    htfd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (w_rec),
        .o_rec_ready (w_rec_ready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_temp      (w_temp),
        .o_hum       (w_hum),
        .o_status    (w_status)
    );

    assign s_axis_tready = w_in_ready;
    assign m_axis_tdata  = {(M_TDATA_W - TEMP_W - HUM_W)'(0), w_hum, w_temp};
    assign m_axis_tuser  = w_status;

endmodule

### src/htfd_frame.sv
// byte position tracking, crc check and frame record register
`timescale 1ns / 1ps

module htfd_frame (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_frame_start,
    input  logic                  i_rec_ready,
    output logic                  o_in_ready,
    output htfd_pkg::t_frame_rec  o_rec
);
    import htfd_pkg::*;

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_tw, n_tw;
    logic        r_tgood, n_tgood;
    logic [15:0] r_hw, n_hw;
    t_frame_rec  r_rec, n_rec;
    logic [2:0]  w_pos;

    // frame start mark forces the first position
    assign w_pos = (i_frame_start || r_pos >= FRAME_BYTES) ? POS_T_MSB : r_pos;

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_tw    = r_tw;
        n_tgood = r_tgood;
        n_hw    = r_hw;
        n_rec   = r_rec;
        if (i_rec_ready) begin
            n_rec.valid = 1'b0;
        end
        if (i_accept) begin
            case (w_pos)
                POS_T_MSB: begin
                    n_tw  = {i_rx_byte, 8'h00};
                    n_crc = crc8_feed(CRC_INIT, i_rx_byte);
                end
                POS_T_LSB: begin
                    n_tw  = {r_tw[15:8], i_rx_byte};
                    n_crc = crc8_feed(r_crc, i_rx_byte);
                end
                POS_T_CRC: begin
                    n_tgood = (r_crc == i_rx_byte);
                    n_crc   = CRC_INIT;
                end
                POS_H_MSB: begin
                    n_hw  = {i_rx_byte, 8'h00};
                    n_crc = crc8_feed(CRC_INIT, i_rx_byte);
                end
                POS_H_LSB: begin
                    n_hw  = {r_hw[15:8], i_rx_byte};
                    n_crc = crc8_feed(r_crc, i_rx_byte);
                end
                POS_H_CRC: begin
                    n_rec.valid     = 1'b1;
                    n_rec.temp_word = r_tw;
                    n_rec.hum_word  = r_hw;
                    if (!r_tgood) begin
                        n_rec.status = STATUS_TEMP_CRC;
                    end else if (r_crc != i_rx_byte) begin
                        n_rec.status = STATUS_HUM_CRC;
                    end else begin
                        n_rec.status = STATUS_OK;
                    end
                    n_crc = CRC_INIT;
                end
                default: begin
                end
            endcase
            n_pos = (w_pos == POS_H_CRC) ? POS_T_MSB : w_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_T_MSB;
            r_crc   <= CRC_INIT;
            r_tw    <= '0;
            r_tgood <= 1'b0;
            r_hw    <= '0;
            r_rec   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_tw    <= n_tw;
            r_tgood <= n_tgood;
            r_hw    <= n_hw;
            r_rec   <= n_rec;
        end
    end

    assign o_in_ready = !r_rec.valid || i_rec_ready;
    assign o_rec      = r_rec;

endmodule

### src/htfd_scale.sv
// fixed point scaling of the raw words: product stage and result register
`timescale 1ns / 1ps

module htfd_scale (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  htfd_pkg::t_frame_rec            i_rec,
    output logic                            o_rec_ready,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [htfd_pkg::TEMP_W-1:0]     o_temp,
    output logic [htfd_pkg::HUM_W-1:0]      o_hum,
    output logic [htfd_pkg::STATUS_W-1:0]   o_status
);
    import htfd_pkg::*;

    logic                r_b_valid;
    logic [STATUS_W-1:0] r_b_status;
    logic [30:0]         r_prod_t;
    logic [29:0]         r_prod_h;

    logic                r_o_valid;
    logic [TEMP_W-1:0]   r_o_temp, n_o_temp;
    logic [HUM_W-1:0]    r_o_hum, n_o_hum;
    logic [STATUS_W-1:0] r_o_status;

    logic        w_adv_o, w_adv_b;
    logic [31:0] w_sum_t, w_sum_h;
    logic [14:0] w_q_t;
    logic [13:0] w_q_h;
    logic [13:0] w_h;

    assign w_adv_o     = !r_o_valid || i_out_ready;
    assign w_adv_b     = !r_b_valid || w_adv_o;
    assign o_rec_ready = w_adv_b;

    // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 while the quotient stays below 2^16
    assign w_sum_t = 32'(r_prod_t) + 32'(r_prod_t[30:16]) + 32'd1;
    assign w_sum_h = 32'(r_prod_h) + 32'(r_prod_h[29:16]) + 32'd1;
    assign w_q_t   = w_sum_t[30:16];
    assign w_q_h   = w_sum_h[29:16];
    assign w_h     = w_q_h - HUM_OFFSET;

    always_comb begin
        n_o_temp = w_q_t - TEMP_OFFSET;
        if (w_q_h < HUM_OFFSET) begin
            n_o_hum = '0;
        end else if (w_h > HUM_MAX) begin
            n_o_hum = HUM_MAX;
        end else begin
            n_o_hum = w_h;
        end
        if (r_b_status != STATUS_OK) begin
            n_o_temp = '0;
            n_o_hum  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_adv_b) begin
                r_b_valid <= i_rec.valid;
            end
            if (w_adv_o) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_b && i_rec.valid) begin
            r_b_status <= i_rec.status;
            r_prod_t   <= 31'(TEMP_SPAN) * 31'(i_rec.temp_word);
            r_prod_h   <= 30'(HUM_SPAN) * 30'(i_rec.hum_word);
        end
        if (w_adv_o && r_b_valid) begin
            r_o_temp   <= n_o_temp;
            r_o_hum    <= n_o_hum;
            r_o_status <= r_b_status;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_temp      = r_o_temp;
    assign o_hum       = r_o_hum;
    assign o_status    = r_o_status;

endmodule

### src/htfd_checker.sv
// port-level checker for the frame decoder, bound to the top level
`timescale 1ns / 1ps
`include "humidity_temperature_frame_decoder_assert.svh"

module htfd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [htfd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [htfd_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
    import htfd_pkg::*;

    // a result offered but not taken stays put
    `HTFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // nothing is offered in the cycle right after reset
    `HTFD_ASSERT_NOW(a_reset_idle, i_clk, i_rst_n, $past(!i_rst_n), !m_axis_tvalid, "result valid right after reset")

    // crc failure carries zero values
    `HTFD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != STATUS_OK, m_axis_tdata == '0, "nonzero values on crc error")

    // humidity clamped and fill bits zero
    `HTFD_ASSERT_NOW(a_hum_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[28:15] <= HUM_MAX && m_axis_tdata[31:29] == 3'd0, "humidity out of range")

endmodule

bind humidity_temperature_frame_decoder htfd_checker u_htfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
